>>> src/mpwm_pkg.sv
package mpwm_pkg;

	localparam int PERIOD_BITS_DEF = 16;
	localparam int LOWEST_NOTE_DEF = 36;
	localparam int SCALE_ENTRIES = 12;
	localparam int IDX_BITS = 4;
	localparam int OCT_BITS = 4;
	localparam int MAX_OCTAVE = 10;
	localparam int HOLD_BITS = 12;
	localparam int DUTY_SHIFT = 8;
	localparam int DIV5_MUL = 52429;
	localparam int DIV5_SHIFT = 18;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_NOTE = 2'd1,
		REQ_LOAD = 2'd2
	} req_type_t;

	typedef struct packed {
		logic tick;
		logic note;
		logic load;
	} req_fire_t;

endpackage

>>> src/midi_note_pwm_tone_generator_core.sv
// note-driven pwm tone generator for a piezo tweeter
// input channel (in_valid/in_ready) takes one request per transfer:
//   tick, play note or load scale entry; only a tick yields a result
// output channel (out_valid/out_ready) returns one pwm_level per tick
// config channel (cfg_valid/cfg_ready) writes tick_rate; always ready,
//   write only while no request is in flight
// a tick waits in the input register from its input transfer until it
//   leaves there, and its result is then loaded into the result register;
//   while the result register is stalled, the tick stays in the input register
// throughput: one request per cycle; note decode, scale lookup, octave
//   shift and duty multiply all fit between the input and result registers
// a rest (note 0) or a note from LOWEST_NOTE up sets the tone and loads
//   a holdoff of tick_rate/20 ticks during which ticks give 0
// reset clears tone period, duty, holdoff, phase and tick_rate; the scale
//   store is not cleared and must be loaded before notes use it
// when the receiver stalls, the result register holds; a tick behind it
//   waits in the input register, non-tick requests still flow
module midi_note_pwm_tone_generator_core #(
	parameter int PERIOD_BITS = mpwm_pkg::PERIOD_BITS_DEF,
	parameter int LOWEST_NOTE = mpwm_pkg::LOWEST_NOTE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [6:0]  note_number,
	input  logic [6:0]  velocity,
	input  logic [3:0]  table_index,
	input  logic [15:0] table_period,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pwm_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import mpwm_pkg::*;

	logic                   valid_s1;
	logic [1:0]             req_type_s1;
	logic [6:0]             note_number_s1;
	logic [6:0]             velocity_s1;
	logic [3:0]             table_index_s1;
	logic [15:0]            table_period_s1;
	logic                   out_valid_q;
	logic                   pwm_level_q;
	logic [HOLD_BITS-1:0]   holdoff_len_q;
	logic [29:0]            hold_prod;
	logic                   stall_out;
	logic                   advance;
	req_fire_t              fire;
	logic                   tone_set;
	logic [PERIOD_BITS-1:0] tone_period;
	logic [PERIOD_BITS-1:0] tone_duty;
	logic                   level;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign pwm_level = pwm_level_q;

	assign stall_out = out_valid_q && !out_ready;
	assign advance = valid_s1 && !((req_type_s1 == REQ_TICK) && stall_out);
	assign in_ready = !valid_s1 || advance;

	// tick_rate/20 as (tick_rate>>2)/5 by reciprocal
	assign hold_prod = 30'(cfg_data[15:2]) * 30'(DIV5_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_len_q <= '0;
		end else if (cfg_valid) begin
			holdoff_len_q <= hold_prod[DIV5_SHIFT +: HOLD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			note_number_s1 <= note_number;
			velocity_s1 <= velocity;
			table_index_s1 <= table_index;
			table_period_s1 <= table_period;
		end
	end

	always_comb begin
		fire = '0;
		if (advance) begin
			unique case (req_type_s1)
				REQ_TICK: fire.tick = 1'b1;
				REQ_NOTE: fire.note = 1'b1;
				REQ_LOAD: fire.load = 1'b1;
				default: ;
			endcase
		end
	end

	mpwm_scale #(
		.PERIOD_BITS(PERIOD_BITS),
		.LOWEST_NOTE(LOWEST_NOTE)
	) u_scale (
		.clk(clk),
		.fire(fire),
		.note_number(note_number_s1),
		.velocity(velocity_s1),
		.table_index(table_index_s1),
		.table_period(table_period_s1),
		.tone_set(tone_set),
		.tone_period(tone_period),
		.tone_duty(tone_duty)
	);

	mpwm_voice #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_voice (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.tone_set(tone_set),
		.tone_period(tone_period),
		.tone_duty(tone_duty),
		.holdoff_len(holdoff_len_q),
		.level(level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire.tick) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire.tick) begin
			pwm_level_q <= level;
		end
	end

endmodule

>>> src/mpwm_scale.sv
module mpwm_scale #(
	parameter int PERIOD_BITS = mpwm_pkg::PERIOD_BITS_DEF,
	parameter int LOWEST_NOTE = mpwm_pkg::LOWEST_NOTE_DEF
) (
	input  logic                   clk,
	input  mpwm_pkg::req_fire_t    fire,
	input  logic [6:0]             note_number,
	input  logic [6:0]             velocity,
	input  logic [3:0]             table_index,
	input  logic [15:0]            table_period,
	output logic                   tone_set,
	output logic [PERIOD_BITS-1:0] tone_period,
	output logic [PERIOD_BITS-1:0] tone_duty
);
	import mpwm_pkg::*;

	localparam int PROD_BITS = PERIOD_BITS + 7;

	logic [PERIOD_BITS-1:0] store_q [SCALE_ENTRIES];
	logic [6:0]             rel;
	logic [OCT_BITS-1:0]    octave;
	logic [6:0]             idx_full;
	logic [IDX_BITS-1:0]    idx;
	logic [PERIOD_BITS-1:0] shifted;
	logic [PROD_BITS-1:0]   prod;
	logic                   is_rest;

	// scale store, no reset
	always_ff @(posedge clk) begin
		if (fire.load && (table_index < IDX_BITS'(SCALE_ENTRIES))) begin
			store_q[table_index] <= PERIOD_BITS'(table_period);
		end
	end

	// octave by parallel threshold compares
	always_comb begin
		rel = note_number - 7'(LOWEST_NOTE);
		octave = '0;
		for (int k = 1; k <= MAX_OCTAVE; k++) begin
			if (rel >= 7'(SCALE_ENTRIES * k)) begin
				octave = octave + OCT_BITS'(1);
			end
		end
		idx_full = rel - (7'(SCALE_ENTRIES) * 7'(octave));
		idx = idx_full[IDX_BITS-1:0];
		shifted = store_q[idx] >> octave;
		prod = PROD_BITS'(shifted) * PROD_BITS'(velocity);
	end

	assign is_rest = (note_number == 7'd0);
	assign tone_set = fire.note && (is_rest || (note_number >= 7'(LOWEST_NOTE)));
	assign tone_period = is_rest ? '0 : shifted;
	assign tone_duty = is_rest ? '0 : PERIOD_BITS'(prod >> DUTY_SHIFT);

endmodule

>>> src/mpwm_voice.sv
module mpwm_voice #(
	parameter int PERIOD_BITS = mpwm_pkg::PERIOD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mpwm_pkg::req_fire_t             fire,
	input  logic                            tone_set,
	input  logic [PERIOD_BITS-1:0]          tone_period,
	input  logic [PERIOD_BITS-1:0]          tone_duty,
	input  logic [mpwm_pkg::HOLD_BITS-1:0]  holdoff_len,
	output logic                            level
);
	import mpwm_pkg::*;

	logic [PERIOD_BITS-1:0] period_q;
	logic [PERIOD_BITS-1:0] duty_q;
	logic [HOLD_BITS-1:0]   holdoff_q;
	logic [PERIOD_BITS-1:0] phase_q;
	logic [PERIOD_BITS-1:0] phase_inc;
	logic [PERIOD_BITS-1:0] phase_nxt;
	logic                   holding;

	assign holding = (holdoff_q != '0);
	assign phase_inc = phase_q + PERIOD_BITS'(1);
	assign phase_nxt = (phase_inc >= period_q) ? '0 : phase_inc;
	assign level = !holding && (phase_nxt < duty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			duty_q <= '0;
			holdoff_q <= '0;
			phase_q <= '0;
		end else if (tone_set) begin
			period_q <= tone_period;
			duty_q <= tone_duty;
			holdoff_q <= holdoff_len;
		end else if (fire.tick) begin
			if (holding) begin
				holdoff_q <= holdoff_q - HOLD_BITS'(1);
			end else begin
				phase_q <= phase_nxt;
			end
		end
	end

endmodule

>>> verif/midi_note_pwm_tone_generator_core_test.sv
`timescale 1ns / 100ps

module midi_note_pwm_tone_generator_core_test;
	import mpwm_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_DIV = 20;
	localparam int NOTES_PER_OCTAVE = 12;
	localparam int LONG_HOLD = 150;

	class tone_checker;
		bit [15:0] rate;
		bit [15:0] scale [SCALE_ENTRIES];
		bit loaded [SCALE_ENTRIES];
		bit [15:0] period;
		bit [15:0] duty;
		bit [15:0] holdoff;
		bit [15:0] phase;
		bit expected_levels [$];
		int errors;
		int ticks_checked;
		int notes;
		int rests;
		int loads;

		function void set_rate(bit [15:0] v);
			rate = v;
		endfunction

		// true unless the note would read a scale entry never loaded
		function bit note_ok(bit [6:0] n);
			if (n < LOWEST_NOTE_DEF)
				return 1'b1;
			return loaded[(n - LOWEST_NOTE_DEF) % NOTES_PER_OCTAVE];
		endfunction

		function void take_request(logic [1:0] req, logic [6:0] n, logic [6:0] vel,
				logic [3:0] ix, logic [15:0] per);
			int rel;
			int oct;
			bit [15:0] p;
			bit [31:0] prod;
			case (req)
			REQ_TICK: begin
				if (holdoff != 0) begin
					holdoff--;
					expected_levels.push_back(1'b0);
				end else begin
					phase = phase + 16'd1;
					if (phase >= period)
						phase = '0;
					expected_levels.push_back(phase < duty);
				end
			end
			REQ_NOTE: begin
				if (n == 0) begin
					period = '0;
					duty = '0;
					holdoff = 16'(rate / HOLD_DIV);
					rests++;
				end else if (n >= LOWEST_NOTE_DEF) begin
					rel = n - LOWEST_NOTE_DEF;
					oct = rel / NOTES_PER_OCTAVE;
					p = scale[rel % NOTES_PER_OCTAVE] >> oct;
					prod = 32'(p) * 32'(vel);
					period = p;
					duty = 16'(prod >> DUTY_SHIFT);
					holdoff = 16'(rate / HOLD_DIV);
					notes++;
				end
			end
			REQ_LOAD: begin
				if (ix < SCALE_ENTRIES) begin
					scale[ix] = per;
					loaded[ix] = 1'b1;
					loads++;
				end
			end
			default: ;
			endcase
		endfunction

		task report(string what);
			if (errors < 100)
				$display("mismatch: %s", what);
			errors++;
		endtask

		task check_level(logic lvl);
			bit want;
			if (expected_levels.size() == 0) begin
				report($sformatf("pwm_level %b with no tick pending", lvl));
				return;
			end
			want = expected_levels.pop_front();
			ticks_checked++;
			if (lvl !== want)
				report($sformatf("tick %0d: pwm_level %b, expected %b", ticks_checked, lvl, want));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] req_type;
	logic [6:0] note_number;
	logic [6:0] velocity;
	logic [3:0] table_index;
	logic [15:0] table_period;
	logic out_valid;
	logic out_ready;
	logic pwm_level;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;

	tone_checker sb;
	bit calm;
	bit hold_req;
	int rate_settings;

	midi_note_pwm_tone_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.note_number(note_number),
		.velocity(velocity),
		.table_index(table_index),
		.table_period(table_period),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pwm_level(pwm_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// called and returns at a falling edge
	task send_req(logic [1:0] rq, logic [6:0] n, logic [6:0] v, logic [3:0] ix,
			logic [15:0] per);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		req_type = rq;
		note_number = n;
		velocity = v;
		table_index = ix;
		table_period = per;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.take_request(rq, n, v, ix, per);
		@(negedge clk);
	endtask

	task send_rand();
		int r;
		logic [6:0] n;
		logic [6:0] v;
		logic [3:0] ix;
		logic [15:0] per;
		n = 7'($urandom);
		v = 7'($urandom);
		ix = 4'($urandom);
		per = 16'($urandom);
		r = $urandom_range(0, 99);
		if (r < 58) begin
			send_req(REQ_TICK, n, v, ix, per);
		end else if (r < 78) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				n = '0;
			else if (r < 3)
				n = 7'($urandom_range(1, LOWEST_NOTE_DEF - 1));
			else
				n = 7'($urandom_range(LOWEST_NOTE_DEF, 127));
			if (!sb.note_ok(n))
				n = '0;
			r = $urandom_range(0, 9);
			if (r == 0)
				v = '0;
			else if (r == 1)
				v = 7'h7f;
			send_req(REQ_NOTE, n, v, ix, per);
		end else if (r < 93) begin
			ix = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(SCALE_ENTRIES, 15))
				: 4'($urandom_range(0, SCALE_ENTRIES - 1));
			per = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
			send_req(REQ_LOAD, n, v, ix, per);
		end else begin
			send_req(REQ_UNUSED, n, v, ix, per);
		end
	endtask

	task wait_idle();
		in_valid = 1'b0;
		while (sb.expected_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task write_rate(logic [15:0] v);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_rate(v);
		rate_settings++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: one transfer check per rising edge, ready changes at the falling edge
	initial begin
		int stall_left;
		int g;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready)
				sb.check_level(pwm_level);
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				out_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				g = pick_gap();
				out_ready = (g == 0);
				if (g > 0)
					stall_left = g - 1;
			end
		end
	end

	initial begin
		logic [15:0] rates [8];
		sb = new;
		calm = 1'b0;
		hold_req = 1'b0;
		rate_settings = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_TICK;
		note_number = '0;
		velocity = '0;
		table_index = '0;
		table_period = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_rate(16'd0);
		for (int i = 0; i < SCALE_ENTRIES; i++) begin
			case (i)
			0: send_req(REQ_LOAD, '0, '0, 4'(i), 16'd0);
			1: send_req(REQ_LOAD, '0, '0, 4'(i), 16'hffff);
			2: send_req(REQ_LOAD, '0, '0, 4'(i), 16'd1);
			3: send_req(REQ_LOAD, '0, '0, 4'(i), 16'd2);
			default: send_req(REQ_LOAD, '0, '0, 4'(i), 16'(10 + i * 5));
			endcase
		end
		send_req(REQ_LOAD, 7'h7f, 7'h7f, 4'd12, 16'h1234);
		send_req(REQ_LOAD, 7'h7f, 7'h7f, 4'd15, 16'hffff);
		send_req(REQ_TICK, 7'h7f, 7'h7f, 4'hf, 16'hffff);
		send_req(REQ_NOTE, 7'd36, 7'h7f, '0, '0);
		send_req(REQ_TICK, '0, '0, '0, '0);
		send_req(REQ_NOTE, 7'd37, 7'h7f, 4'hf, 16'hffff);
		send_req(REQ_TICK, '0, '0, '0, '0);
		send_req(REQ_TICK, '0, '0, '0, '0);
		send_req(REQ_NOTE, 7'd35, 7'h40, '0, '0);
		send_req(REQ_NOTE, 7'd127, 7'h7f, '0, '0);
		send_req(REQ_NOTE, 7'd40, 7'h40, '0, '0);
		repeat (3) send_req(REQ_TICK, '0, '0, '0, '0);
		send_req(REQ_NOTE, 7'd0, 7'h7f, '0, '0);
		send_req(REQ_TICK, '0, '0, '0, '0);
		send_req(REQ_UNUSED, 7'h7f, 7'h7f, 4'hf, 16'hffff);
		send_req(REQ_TICK, '0, '0, '0, '0);

		rates = '{16'hffff, 16'd0, 16'd19, 16'd20, 16'd41, 16'($urandom_range(0, 300)),
			16'($urandom_range(0, 120)), 16'd100};
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_rate(rates[ph]);
			if (ph == 2) begin
				// receiver holds off while ticks keep coming
				calm = 1'b1;
				hold_req = 1'b1;
				repeat (40) send_req(REQ_TICK, 7'($urandom), 7'($urandom), 4'($urandom),
					16'($urandom));
			end
			calm = ($urandom_range(0, 3) == 0);
			repeat (95) send_rand();
		end
		in_valid = 1'b0;
		calm = 1'b0;

		while (sb.expected_levels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("checked %0d tick levels after %0d notes, %0d rests and %0d scale loads",
			sb.ticks_checked, sb.notes, sb.rests, sb.loads);
		$display("tick rate written %0d times, %0d mismatches", rate_settings, sb.errors);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> midi_note_pwm_tone_generator_core.f
src/mpwm_pkg.sv
src/mpwm_scale.sv
src/mpwm_voice.sv
src/midi_note_pwm_tone_generator_core.sv
verif/midi_note_pwm_tone_generator_core_test.sv
